>>> sv/disparity_row_infill_defines.svh
// assertion macros shared by the disparity row infill rtl
// depends on i_clk and i_rst_n being visible in the including module
`ifndef DISPARITY_ROW_INFILL_DEFINES_SVH
`define DISPARITY_ROW_INFILL_DEFINES_SVH

// condition pre implies post in the same cycle
`define DRI_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("disparity_row_infill: assertion failed");

// condition pre implies post in the following cycle
`define DRI_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("disparity_row_infill: assertion failed");

`endif

>>> sv/dri_pkg.sv
// shared types and constants of the disparity row infill block
// no dependencies
package dri_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int ROW_WIDTH_RST = 2048;
    localparam int RW_W          = 12;
    localparam int PIX_W         = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // register word index (byte address / 4)
    typedef enum logic [APB_AW-3:0] {
        REG_ROW_WIDTH = 1'b0
    } t_reg_idx;

    // one result beat
    typedef struct packed {
        logic              ov;
        logic [PIX_W-1:0]  pix;
        logic              row_end;
    } t_result;

    // control carried along the read pipeline
    typedef struct packed {
        logic valid;
        logic ov;
        logic last;
        logic seen;
        logic rb;
    } t_rd_ctl;

endpackage

>>> sv/disparity_row_infill.sv
// disparity row infill top level: row store, gap tables, read pipeline, result fifo
// depends on dri_pkg and disparity_row_infill_defines.svh
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-------------------------------------------
//  input     | in        | i_valid / o_ready   | i_req_type, i_disparity_in
//  result    | out       | o_valid / i_ready   | o_out_valid, o_disparity_out, o_row_end
//  config    | in        | apb psel / penable  | paddr, pwdata, prdata (row_width at 0x0)
//
//  one input beat per cycle is taken while o_ready is high; every input beat yields exactly one result beat
//  a result is offered once its beat has passed the row store and gap segment read at
//  the accepting edge, the gap table read and the result fifo write; the gap table
//  read depends on the gap segment read, which sets the latency
//  a four-entry result fifo with credit counting keeps o_ready high under i_ready stalls
//  until four beats are outstanding
//  synchronous active-low reset clears control; the memories are not cleared
`include "disparity_row_infill_defines.svh"

module disparity_row_infill
    import dri_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel input
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_req_type,
    input  logic [PIX_W-1:0]  i_disparity_in,
    // result output
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_out_valid,
    output logic [PIX_W-1:0]  o_disparity_out,
    output logic              o_row_end,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // column index, width and memory address sizes
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int AW      = CW + 1;
    localparam int DEPTH   = 2 ** AW;
    localparam int EFF_RST = (ROW_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : ROW_WIDTH_RST;
    localparam int FP_W    = $clog2(FIFO_DEPTH);
    localparam int FC_W    = $clog2(FIFO_DEPTH + 1);

    // bank-major memories: address is {bank, column}
    logic [PIX_W-1:0] r_row_store [DEPTH];
    logic [CW-1:0]    r_gap_seg   [DEPTH];
    logic [PIX_W-1:0] r_gap_fill  [DEPTH];

    // configuration
    logic [RW_W-1:0] r_row_width;
    logic [WW-1:0]   r_eff;
    logic [WW-1:0]   n_eff;
    logic            cfg_wr;

    // row writer state
    logic [CW-1:0]          r_cc;
    logic [CW-1:0]          r_gap;
    logic signed [PIX_W-1:0] r_prev;
    logic [1:0]             r_seen;
    logic                   r_wb;
    logic                   r_out_rdy;
    logic                   r_has_pix;

    // per-beat decode
    logic                    acc;
    logic                    is_pix;
    logic                    noop;
    logic                    do_step;
    logic                    last;
    logic [CW-1:0]           col;
    logic [CW-1:0]           gl;
    logic [CW-1:0]           start;
    logic signed [PIX_W-1:0] v;
    logic                    vpos;
    logic signed [PIX_W-1:0] fill;
    logic                    rb;
    logic                    gf_we;
    logic [PIX_W-1:0]        gf_wdata;

    // read pipeline
    t_rd_ctl          r_s1;
    t_rd_ctl          r_s2;
    logic [PIX_W-1:0] r_rs_q;
    logic [CW-1:0]    r_seg_q;
    logic [PIX_W-1:0] r_s2_pix;
    logic [PIX_W-1:0] r_gf_q;
    t_result          res;
    logic             fill_use;

    // result fifo and credit count
    t_result          r_fifo [FIFO_DEPTH];
    logic [FP_W-1:0]  r_wp;
    logic [FP_W-1:0]  r_rp;
    logic [FC_W-1:0]  r_fcnt;
    logic [FC_W-1:0]  r_cnt;
    logic             pop;
    t_result          head;

    // ------------------------------------------------------------------
    // apb register: row_width, with the clamped width kept alongside
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_ROW_WIDTH);

    always_comb begin
        if (pwdata[RW_W-1:0] == '0) begin
            n_eff = WW'(1);
        end else if ({20'd0, pwdata[RW_W-1:0]} > 32'(MAX_WIDTH)) begin
            n_eff = WW'(MAX_WIDTH);
        end else begin
            n_eff = WW'(pwdata[RW_W-1:0]);
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_ROW_WIDTH: prdata = {{(APB_DW-RW_W){1'b0}}, r_row_width};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RW_W'(ROW_WIDTH_RST);
            r_eff       <= WW'(EFF_RST);
        end else if (cfg_wr) begin
            r_row_width <= pwdata[RW_W-1:0];
            r_eff       <= n_eff;
        end
    end

    // ------------------------------------------------------------------
    // beat decode: column, gap start, fill value
    // ------------------------------------------------------------------
    assign acc     = i_valid && o_ready;
    assign is_pix  = !i_req_type;
    // a flush with nothing pending or in progress only yields an empty result
    assign noop    = !is_pix && !r_out_rdy && (r_cc == '0);
    assign do_step = acc && !noop;
    assign rb      = ~r_wb;

    always_comb begin
        // a counter beyond a narrowed width lands on the last column
        last  = (WW'(r_cc) + WW'(1)) >= r_eff;
        col   = last ? CW'(r_eff - WW'(1)) : r_cc;
        gl    = (r_gap > col) ? col : r_gap;
        start = col - gl;
        v     = is_pix ? $signed(i_disparity_in) : '0;
        vpos  = (v > 0);
        fill  = (r_seen[r_wb] && (r_prev < v)) ? r_prev : v;
        // a valid pixel closes the open gap; an invalid last pixel closes a trailing gap
        gf_we    = do_step && ((vpos && (gl != '0)) || (!vpos && last && r_seen[r_wb]));
        gf_wdata = vpos ? fill : r_prev;
    end

    // ------------------------------------------------------------------
    // row writer state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc      <= '0;
            r_gap     <= '0;
            r_prev    <= '0;
            r_seen    <= '0;
            r_wb      <= 1'b0;
            r_out_rdy <= 1'b0;
            r_has_pix <= 1'b0;
        end else if (do_step) begin
            if (vpos) begin
                r_seen[r_wb] <= 1'b1;
                r_prev       <= v;
            end
            if (last) begin
                // swap banks; the bank about to be written starts with no valid pixel
                r_cc      <= '0;
                r_gap     <= '0;
                r_out_rdy <= r_has_pix || is_pix;
                r_has_pix <= 1'b0;
                r_wb      <= rb;
                r_seen[rb] <= 1'b0;
            end else begin
                r_cc  <= col + CW'(1);
                r_gap <= vpos ? '0 : gl + CW'(1);
                if (is_pix) begin
                    r_has_pix <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // memories: bank write and store/segment read at acceptance; fill read from the registered segment
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_row_store[{r_wb, col}] <= v;
        end
        r_rs_q <= r_row_store[{rb, col}];
    end

    always_ff @(posedge i_clk) begin
        if (do_step && !vpos) begin
            r_gap_seg[{r_wb, col}] <= start;
        end
        r_seg_q <= r_gap_seg[{rb, col}];
    end

    // a same-cycle read of an entry being written returns the older value
    always_ff @(posedge i_clk) begin
        if (gf_we) begin
            r_gap_fill[{r_wb, start}] <= gf_wdata;
        end
        r_gf_q <= r_gap_fill[{r_s1.rb, r_seg_q}];
    end

    // ------------------------------------------------------------------
    // read pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1.valid <= acc;
            r_s1.ov    <= r_out_rdy && !noop;
            r_s1.last  <= last;
            r_s1.seen  <= r_seen[rb];
            r_s1.rb    <= rb;
            r_s2       <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_pix <= r_rs_q;
    end

    // invalid stored pixel of a row with a valid pixel takes its gap's fill
    always_comb begin
        fill_use = r_s2.seen && ($signed(r_s2_pix) <= 0);
        if (r_s2.ov) begin
            res.ov      = 1'b1;
            res.pix     = fill_use ? r_gf_q : r_s2_pix;
            res.row_end = r_s2.last;
        end else begin
            res = '0;
        end
    end

    // ------------------------------------------------------------------
    // result fifo; credits cover beats in the read pipeline and the fifo
    // ------------------------------------------------------------------
    assign o_ready = r_cnt < FC_W'(FIFO_DEPTH);
    assign o_valid = r_fcnt != '0;
    assign pop     = o_valid && i_ready;
    assign head    = r_fifo[r_rp];

    assign o_out_valid     = head.ov;
    assign o_disparity_out = head.pix;
    assign o_row_end       = head.row_end;

    always_ff @(posedge i_clk) begin
        if (r_s2.valid) begin
            r_fifo[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
            r_cnt  <= '0;
        end else begin
            if (r_s2.valid) begin
                r_wp <= r_wp + FP_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FP_W'(1);
            end
            r_fcnt <= r_fcnt + FC_W'(r_s2.valid) - FC_W'(pop);
            r_cnt  <= r_cnt + FC_W'(acc) - FC_W'(pop);
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `DRI_ASSERT_IMPL(a_cnt_max, 1'b1, r_cnt <= FC_W'(FIFO_DEPTH))
    `DRI_ASSERT_IMPL(a_cnt_match, 1'b1, r_cnt == r_fcnt + FC_W'(r_s1.valid) + FC_W'(r_s2.valid))
    `DRI_ASSERT_IMPL(a_gap_bound, 1'b1, r_gap <= r_cc)
    `DRI_ASSERT_NEXT(a_row_wrap, do_step && last, (r_cc == '0) && (r_wb != $past(r_wb)))

endmodule

>>> tb/sv/dri_check_pkg.sv
`timescale 1ns / 1ps
// row gap infill predictor and result scoreboard for the disparity_row_infill test
// depends on dri_pkg for the result beat layout, pixel width and row width limits
package dri_check_pkg;
    import dri_pkg::*;

    // input beat kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    class infill_scoreboard;
        // two banks of one row each, bank-major
        logic signed [PIX_W-1:0] pix_mem  [2*MAX_WIDTH_DEF];
        logic [10:0]             seg_mem  [2*MAX_WIDTH_DEF];
        logic signed [PIX_W-1:0] fill_mem [2*MAX_WIDTH_DEF];
        logic [RW_W-1:0]         row_width;
        int unsigned             col_cnt;
        int unsigned             gap_len;
        logic signed [PIX_W-1:0] prev_val;
        logic signed [PIX_W-1:0] last_val [2];
        bit                      seen [2];
        int unsigned             wbank;
        bit                      out_ready;
        bit                      has_pix;
        int unsigned             ready_w;
        t_result                 filled_q [$];
        int                      n_bad;
        int                      n_seen;

        function new();
            foreach (pix_mem[k]) begin
                pix_mem[k]  = '0;
                seg_mem[k]  = '0;
                fill_mem[k] = '0;
            end
            row_width = RW_W'(ROW_WIDTH_RST);
            col_cnt   = 0;
            gap_len   = 0;
            prev_val  = '0;
            last_val  = '{'0, '0};
            seen      = '{1'b0, 1'b0};
            wbank     = 0;
            out_ready = 1'b0;
            has_pix   = 1'b0;
            ready_w   = 0;
            n_bad     = 0;
            n_seen    = 0;
        endfunction

        function int unsigned effective(input int unsigned w);
            if (w < 1) return 1;
            if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return w;
        endfunction

        function void set_width(input logic [RW_W-1:0] v);
            row_width = v;
        endfunction

        function int pending();
            return filled_q.size();
        endfunction

        // one accepted input beat: emit the filled pixel of the stored row, store the new one
        function void note_beat(input logic req, input logic signed [PIX_W-1:0] d);
            int unsigned w, c, wb, rb, wi, ri, seg;
            logic signed [PIX_W-1:0] v, s, fill;
            bit at_end;
            t_result r;
            r = '0;
            w = effective(row_width);
            c = (col_cnt >= w) ? w - 1 : col_cnt;
            if (req == REQ_FLUSH && !out_ready && col_cnt == 0) begin
                filled_q.push_back(r);
                return;
            end
            at_end = (c + 1 >= w);
            wb = wbank;
            rb = wb ^ 1;
            wi = wb * MAX_WIDTH_DEF + c;
            ri = rb * MAX_WIDTH_DEF + c;
            if (out_ready) begin
                s = pix_mem[ri];
                if (s <= 0 && seen[rb]) begin
                    seg = seg_mem[ri];
                    s = fill_mem[rb * MAX_WIDTH_DEF + seg];
                end
                r.ov = 1'b1;
                r.pix = s;
                r.row_end = at_end;
            end
            if (req == REQ_FLUSH) begin
                v = '0;
            end else begin
                v = d;
                has_pix = 1'b1;
            end
            pix_mem[wi] = v;
            if (gap_len > c) gap_len = c;
            if (v > 0) begin
                // closing a gap: the smaller neighbor, or this one for a leading gap
                if (gap_len > 0) begin
                    fill = v;
                    if (seen[wb] && prev_val < fill) fill = prev_val;
                    fill_mem[wb * MAX_WIDTH_DEF + c - gap_len] = fill;
                end
                seen[wb] = 1'b1;
                prev_val = v;
                last_val[wb] = v;
                gap_len = 0;
            end else begin
                seg_mem[wi] = 11'(c - gap_len);
                gap_len++;
            end
            if (at_end) begin
                // trailing gap takes the last valid pixel
                if (gap_len > 0 && seen[wb])
                    fill_mem[wb * MAX_WIDTH_DEF + c + 1 - gap_len] = last_val[wb];
                out_ready = has_pix;
                ready_w = w;
                has_pix = 1'b0;
                wbank = rb;
                seen[rb] = 1'b0;
                col_cnt = 0;
                gap_len = 0;
            end else begin
                col_cnt = c + 1;
            end
            filled_q.push_back(r);
        endfunction

        function void flag(input string what, input int want, input int got);
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch on %s at result %0d: expected %0d, got %0d",
                         what, n_seen, want, got);
        endfunction

        function void check_beat(input t_result got);
            t_result want;
            n_seen++;
            if (filled_q.size() == 0) begin
                flag("result with none outstanding", 0, int'(got.ov));
                return;
            end
            want = filled_q.pop_front();
            if (got.ov !== want.ov) flag("out_valid", want.ov, got.ov);
            if (got.pix !== want.pix) flag("disparity_out", $signed(want.pix), $signed(got.pix));
            if (got.row_end !== want.row_end) flag("row_end", want.row_end, got.row_end);
        endfunction
    endclass

endpackage

>>> tb/sv/disparity_row_infill_test.sv
`timescale 1ns / 1ps
// self-checking test of disparity_row_infill: pixel and flush beats in, filled rows out
// depends on dri_pkg and dri_check_pkg; drives both valid/ready channels and the apb port
module disparity_row_infill_test;
    import dri_pkg::*;
    import dri_check_pkg::*;

    localparam int RAND_BEATS  = 1700;
    localparam int CALM_AFTER  = 1450;  // last stretch runs without idling
    localparam int HOLD_AT     = 400;   // input beat count that triggers the long stall
    localparam int HOLD_CYCLES = 250;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_req_type;
    logic [PIX_W-1:0]  i_disparity_in;
    logic              o_valid;
    logic              i_ready;
    logic              o_out_valid;
    logic [PIX_W-1:0]  o_disparity_out;
    logic              o_row_end;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    infill_scoreboard board = new();
    int beats_in = 0;
    bit calm     = 1'b0;   // no idling on either side
    bit holding  = 1'b0;   // receiver in its long stall, sender keeps pushing

    always #5 i_clk = ~i_clk;

    disparity_row_infill dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_disparity_in (i_disparity_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_valid    (o_out_valid),
        .o_disparity_out(o_disparity_out),
        .o_row_end      (o_row_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // result side: values read here are the ones present before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            // packed in field order: out_valid, pixel, row end
            board.check_beat({o_out_valid, o_disparity_out, o_row_end});
        end
    end

    // random valid disparity (half drawn small, so min selection is exercised) or an invalid one
    function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
        bit good;
        case (mode)
            0: good = 1'b1;                          // dense row
            1: good = ($urandom_range(0, 4) == 0);   // sparse row
            2: good = 1'b0;                          // no valid pixel at all
            default: good = 1'($urandom_range(0, 1));
        endcase
        if (good)
            return $urandom_range(0, 1) ? 16'($urandom_range(1, 60)) : 16'($urandom_range(1, 32767));
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 16'h8000;
            default: return 16'($urandom_range(32768, 65535));  // negative
        endcase
    endfunction

    // one input beat, held until accepted; optional random gap afterwards
    task automatic send_beat(input logic req, input logic [PIX_W-1:0] d);
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_disparity_in <= d;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        board.note_beat(req, d);
        beats_in++;
        if (!calm && !holding && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic park();
        i_valid <= 1'b0;
    endtask

    // mostly pixels, with the odd flush beat landing inside the row
    task automatic send_row(input int unsigned w, input int mode);
        repeat (w) begin
            if ($urandom_range(0, 24) == 0) send_beat(REQ_FLUSH, 16'($urandom));
            else send_beat(REQ_PIXEL, pick_pixel(mode));
        end
    endtask

    // flush beats close any open row and push out the stored one
    task automatic drain();
        while (board.out_ready || board.col_cnt != 0) send_beat(REQ_FLUSH, 16'($urandom));
    endtask

    // wait for every outstanding result plus the pipeline depth
    task automatic settle();
        park();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROW_WIDTH) board.set_width(val[RW_W-1:0]);
    endtask

    // result side ready: random stalls, bursts of ready, one long hold-off
    initial begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!hold_done && beats_in >= HOLD_AT && i_valid === 1'b1) begin
                // block fills its result fifo and must drop o_ready
                holding = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding = 1'b0;
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int directed_rows [3][5] = '{
            '{-5, 7, 0, -32768, 3},           // leading gap, inner gap between 7 and 3
            '{32767, -1, 1, 0, 0},            // inner gap takes 1, trailing gap takes 1
            '{-32768, 0, -1, -200, 0}         // nothing valid: row passes unchanged
        };
        int unsigned nw, w_eff, rows, phase, rand_beats, mark;
        int spins;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_req_type     <= REQ_PIXEL;
        i_disparity_in <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing stored and no row open: flush beats give out_valid low
        send_beat(REQ_FLUSH, 16'h7fff);
        send_beat(REQ_FLUSH, 16'h8000);
        settle();

        write_reg(REG_ROW_WIDTH, 5);
        foreach (directed_rows[r, c]) send_beat(REQ_PIXEL, 16'(directed_rows[r][c]));
        // flush inside a row counts as an invalid zero pixel
        send_beat(REQ_PIXEL, 16'd4);
        send_beat(REQ_FLUSH, 16'hffff);
        send_beat(REQ_PIXEL, 16'd9);
        send_beat(REQ_FLUSH, 16'h0001);
        send_beat(REQ_PIXEL, 16'd32767);
        // flush-only row drains the last one and is itself never output
        drain();
        settle();

        // width extremes first (1, 0 acting as 1, minimum 2, all ones clamped to max),
        // then random widths
        phase = 0;
        rand_beats = 0;
        while (rand_beats < RAND_BEATS) begin
            case (phase)
                0: nw = 1;
                1: nw = 0;
                2: nw = 2;
                3: nw = 4095;
                default: begin
                    case ($urandom_range(0, 9))
                        0: nw = $urandom_range(0, 1);
                        1, 2, 3, 4, 5: nw = $urandom_range(2, 16);
                        6, 7: nw = $urandom_range(17, 64);
                        8: nw = $urandom_range(65, 300);
                        default: nw = $urandom_range(2, 6);
                    endcase
                end
            endcase
            w_eff = board.effective(nw);
            mark = beats_in;
            // a stored row may be read at a narrower width; an open row or a wider
            // width would read store entries that were never written, so flush first
            if (board.col_cnt != 0 || (board.out_ready && w_eff > board.ready_w)) drain();
            settle();
            write_reg(REG_ROW_WIDTH, nw);
            if (w_eff > 300) begin
                // clamped maximum width: open a row, then finish it at a width just past it
                repeat (20) send_beat(REQ_PIXEL, pick_pixel(3));
                settle();
                write_reg(REG_ROW_WIDTH, 24);
                repeat (4) send_beat(REQ_PIXEL, pick_pixel(3));
            end else begin
                rows = $urandom_range(1, (w_eff <= 4) ? 12 : ((w_eff <= 40) ? 6 : 2));
                repeat (rows) send_row(w_eff, $urandom_range(0, 3));
                // sometimes leave a row half written, closed later by flush beats
                if (w_eff > 1 && $urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, w_eff - 1))
                        send_beat(REQ_PIXEL, pick_pixel($urandom_range(0, 3)));
                end
            end
            rand_beats += beats_in - mark;
            if (rand_beats > CALM_AFTER) calm = 1'b1;
            phase++;
        end
        drain();
        park();

        spins = 0;
        while (board.pending() != 0 && spins < 10000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (8) @(posedge i_clk);
        if (board.pending() != 0) board.n_bad++;
        if (board.n_bad == 0) begin
            $display("disparity_row_infill test passed");
        end else begin
            $display("disparity_row_infill test failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin : watchdog
        #(64'd20_000_000);
        $display("disparity_row_infill test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/dri_pkg.sv
sv/disparity_row_infill.sv
tb/sv/dri_check_pkg.sv
tb/sv/disparity_row_infill_test.sv
